@@ hdl/double_to_int32_saturating_macros.svh @@
// Assertion macros for the double to int32 converter.
`ifndef DOUBLE_TO_INT32_SATURATING_MACROS_SVH
`define DOUBLE_TO_INT32_SATURATING_MACROS_SVH
`ifndef SYNTHESIS
`define D2I_ASSERT_IMPL(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
`define D2I_ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("assertion failed");
`else
`define D2I_ASSERT_IMPL(label, clk, rst, prop)
`define D2I_ASSERT_NEXT(label, clk, rst, a, b)
`endif
`endif

@@ hdl/d2i_pkg.sv @@
package d2i_pkg;
   localparam int ExpWidth  = 11;
   localparam int FracWidth = 52;
   localparam logic [ExpWidth-1:0] ExpAllOnes = 11'h7FF;
   localparam logic [ExpWidth-1:0] ExpBias    = 11'd1023;
   localparam logic [31:0] S32MaxPat = 32'h7FFF_FFFF;
   localparam logic [31:0] S32MinPat = 32'h8000_0000;
   localparam logic [31:0] U32MaxPat = 32'hFFFF_FFFF;
   localparam logic MODE_SIGNED   = 1'b0;
   localparam logic MODE_UNSIGNED = 1'b1;

   typedef struct packed {
      logic        neg;
      logic        zero;
      logic        sat;
      logic [4:0]  shift;
      logic [31:0] mant;
   } d2i_dec_type;
endpackage

@@ hdl/d2i_decode.sv @@
module d2i_decode import d2i_pkg::*; (
   input  logic [63:0] double_bits,
   input  logic        mode,
   output d2i_dec_type dec
);
   logic [ExpWidth-1:0] bexp;
   logic                frac_nz;
   logic                is_max;
   logic [ExpWidth-1:0] e;

   always_comb begin
      bexp    = double_bits[62:52];
      frac_nz = |double_bits[51:0];
      e       = bexp - ExpBias;
      is_max  = (bexp == ExpAllOnes);
      dec.neg   = double_bits[63] && (mode == MODE_SIGNED);
      dec.zero  = 1'b0;
      dec.sat   = 1'b0;
      dec.shift = 5'd31 - e[4:0];
      // Top 32 bits of the mantissa with hidden bit; shifted right by 31-e.
      dec.mant  = {1'b1, double_bits[51:21]};
      if (is_max && frac_nz) begin
         dec.zero = 1'b1;
      end else if (mode == MODE_UNSIGNED && double_bits[63]) begin
         dec.zero = 1'b1;
      end else if (is_max) begin
         dec.sat = 1'b1;
      end else if (bexp < ExpBias) begin
         dec.zero = 1'b1;
      end else if (mode == MODE_SIGNED && bexp >= ExpBias + 11'd31) begin
         dec.sat = 1'b1;
      end else if (mode == MODE_UNSIGNED && bexp >= ExpBias + 11'd32) begin
         dec.sat = 1'b1;
      end
   end
endmodule

@@ hdl/d2i_shift.sv @@
module d2i_shift import d2i_pkg::*; (
   input  d2i_dec_type dec,
   input  logic        mode,
   output logic [31:0] result
);
   logic [31:0] mag;

   always_comb begin
      mag = dec.mant >> dec.shift;
      if (dec.zero) begin
         result = '0;
      end else if (dec.sat) begin
         if (mode == MODE_UNSIGNED) begin
            result = U32MaxPat;
         end else begin
            result = dec.neg ? S32MinPat : S32MaxPat;
         end
      end else begin
         result = dec.neg ? (32'd0 - mag) : mag;
      end
   end
endmodule

@@ hdl/double_to_int32_saturating.sv @@
// Channel   | Ports                              | Handshake
// request   | req_double_bits, req_mode          | start / busy
// response  | rsp_int_result                     | rsp_valid strobe, one cycle
//
// One beat is taken each cycle; busy is tied low.
// Each request beat is registered, decoded and shifted in one pass, then
// registered as the result.
// Reset (synchronous, active high) clears the valid pipeline only.
// The receiver cannot stall, so nothing ever backs up.
`include "double_to_int32_saturating_macros.svh"
module double_to_int32_saturating import d2i_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [63:0] req_double_bits,
   input  logic        req_mode,
   output logic        rsp_valid,
   output logic [31:0] rsp_int_result
);
   logic        in_vld_ff, in_vld_in;
   logic [63:0] bits_ff;
   logic        mode_ff;
   logic        out_vld_ff;
   logic [31:0] res_ff, res_in;
   d2i_dec_type dec;

   assign busy      = 1'b0;
   assign in_vld_in = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= in_vld_ff;
      end
   end

   // Payload registers need no reset.
   always_ff @(posedge clock) begin
      if (in_vld_in) begin
         bits_ff <= req_double_bits;
         mode_ff <= req_mode;
      end
      res_ff <= res_in;
   end

   d2i_decode u_decode (.double_bits(bits_ff), .mode(mode_ff), .dec(dec));
   d2i_shift  u_shift  (.dec(dec), .mode(mode_ff), .result(res_in));

   assign rsp_valid      = out_vld_ff;
   assign rsp_int_result = res_ff;

   `D2I_ASSERT_NEXT(a_pipe, clock, reset, start, ##1 rsp_valid)
   `D2I_ASSERT_IMPL(a_nan_zero, clock, reset,
      (in_vld_ff && bits_ff[62:52] == ExpAllOnes && bits_ff[51:0] != 52'd0)
      |=> (rsp_int_result == 32'd0))
   `D2I_ASSERT_IMPL(a_uneg_zero, clock, reset,
      (in_vld_ff && mode_ff == MODE_UNSIGNED && bits_ff[63])
      |=> (rsp_int_result == 32'd0))
endmodule

@@ test/tb_top.sv @@
module tb_top import d2i_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   // The converter takes a beat at a rising edge where start is high and busy
   // is low. Each beat produces exactly one result, registered at the input and
   // again at the output, shown for one cycle under rsp_valid. The receiver cannot hold results off.

   localparam int LatencyCycles = 2;
   localparam int RandomBeats   = 750;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [63:0] req_double_bits;
   logic        req_mode;
   logic        rsp_valid;
   logic [31:0] rsp_int_result;

   // One row of the directed table. When has_known is set, the result is
   // typed in and is checked against the prediction as well.
   typedef struct {
      logic [63:0] bits;
      logic        mode;
      logic        has_known;
      logic [31:0] known;
   } conv_row_type;

   logic [31:0] pending_ints[$];
   int          error_count;

   double_to_int32_saturating uut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_double_bits(req_double_bits),
      .req_mode       (req_mode),
      .rsp_valid      (rsp_valid),
      .rsp_int_result (rsp_int_result)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Works out the integer that the converter must give for one double.
   function automatic logic [31:0] truncate_to_int(logic [63:0] bits, logic mode);
      logic        neg;
      logic [10:0] bexp;
      logic [51:0] frac;
      int          e;
      logic [52:0] mant;
      logic [31:0] mag;
      neg  = bits[63];
      bexp = bits[62:52];
      frac = bits[51:0];
      e    = int'(bexp) - 1023;
      mant = {1'b1, frac};
      mag  = 32'h0;
      if (e >= 0 && e <= 31) begin
         mag = 32'(mant >> (52 - e));
      end
      if (mode == MODE_UNSIGNED) begin
         // Any set sign bit gives zero, negative infinity and NaN included.
         if (neg) return 32'h0;
         if (bexp == ExpAllOnes) return (frac != 0) ? 32'h0 : U32MaxPat;
         if (e < 0) return 32'h0;
         if (e >= 32) return U32MaxPat;
         return mag;
      end
      if (bexp == ExpAllOnes) begin
         if (frac != 0) return 32'h0;
         return neg ? S32MinPat : S32MaxPat;
      end
      if (e < 0) return 32'h0;
      if (e >= 31) return neg ? S32MinPat : S32MaxPat;
      return neg ? (32'h0 - mag) : mag;
   endfunction

   // Random doubles lean on exponents near the interesting window so that
   // shifts of every amount and both saturation edges are hit often.
   function automatic logic [63:0] random_double();
      logic [63:0] bits;
      int          pick;
      bits = {$urandom, $urandom};
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
         bits[62:52] = 11'(1023 + $urandom_range(0, 33) - 1);
      end else if (pick == 6) begin
         bits[62:52] = ExpAllOnes;
         if ($urandom_range(0, 1) == 0) bits[51:0] = '0;
      end else if (pick == 7) begin
         bits[62:52] = '0;
      end
      return bits;
   endfunction

   // Result checker: every strobe must match the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_ints.size() == 0) begin
            $error("int_result: unexpected beat, actual %h", rsp_int_result);
            error_count++;
         end else begin
            if (rsp_int_result !== pending_ints[0]) begin
               $error("int_result: expected %h, actual %h",
                      pending_ints[0], rsp_int_result);
               error_count++;
            end
            void'(pending_ints.pop_front());
         end
      end
   end

   // Drives one beat, with a random idle gap first when idling is on.
   task automatic send_beat(logic [63:0] bits, logic mode, bit may_idle);
      while (may_idle && $urandom_range(0, 99) < 37) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start           <= 1'b1;
      req_double_bits <= bits;
      req_mode        <= mode;
      do @(posedge clock); while (busy);
      pending_ints.push_back(truncate_to_int(bits, mode));
   endtask

   initial begin
      conv_row_type directed[$];
      logic [63:0]  rbits;
      logic         rmode;
      int           waited;
      error_count     = 0;
      reset           <= 1'b1;
      start           <= 1'b0;
      req_double_bits <= '0;
      req_mode        <= MODE_SIGNED;

      // Extremes, both zeros, subnormals, NaN of both signs, both infinities,
      // the saturation edges and the exact minimum of int32, in both modes.
      directed.push_back('{64'h0000_0000_0000_0000, MODE_SIGNED,   1, 32'h0});
      directed.push_back('{64'h8000_0000_0000_0000, MODE_UNSIGNED, 1, 32'h0});
      directed.push_back('{64'h000F_FFFF_FFFF_FFFF, MODE_SIGNED,   1, 32'h0});
      directed.push_back('{64'h7FF8_0000_0000_0000, MODE_SIGNED,   1, 32'h0});
      directed.push_back('{64'hFFFF_FFFF_FFFF_FFFF, MODE_SIGNED,   1, 32'h0});
      directed.push_back('{64'h7FF0_0000_0000_0001, MODE_UNSIGNED, 1, 32'h0});
      directed.push_back('{64'h7FF0_0000_0000_0000, MODE_SIGNED,   1, S32MaxPat});
      directed.push_back('{64'hFFF0_0000_0000_0000, MODE_SIGNED,   1, S32MinPat});
      directed.push_back('{64'h7FF0_0000_0000_0000, MODE_UNSIGNED, 1, U32MaxPat});
      directed.push_back('{64'hFFF0_0000_0000_0000, MODE_UNSIGNED, 1, 32'h0});
      directed.push_back('{64'h3FEF_FFFF_FFFF_FFFF, MODE_SIGNED,   1, 32'h0});
      directed.push_back('{64'h3FF0_0000_0000_0000, MODE_SIGNED,   1, 32'h1});
      directed.push_back('{64'hBFF0_0000_0000_0000, MODE_SIGNED,   1, 32'hFFFF_FFFF});
      directed.push_back('{64'hBFF0_0000_0000_0000, MODE_UNSIGNED, 1, 32'h0});
      directed.push_back('{64'hC1E0_0000_0000_0000, MODE_SIGNED,   1, S32MinPat});
      directed.push_back('{64'h41E0_0000_0000_0000, MODE_SIGNED,   1, S32MaxPat});
      directed.push_back('{64'h41DF_FFFF_FFFF_FFFF, MODE_SIGNED,   0, 32'h0});
      directed.push_back('{64'hC1DF_FFFF_FFFF_FFFF, MODE_SIGNED,   0, 32'h0});
      directed.push_back('{64'h41EF_FFFF_FFFF_FFFF, MODE_UNSIGNED, 1, U32MaxPat});
      directed.push_back('{64'h41F0_0000_0000_0000, MODE_UNSIGNED, 1, U32MaxPat});
      directed.push_back('{64'h7FEF_FFFF_FFFF_FFFF, MODE_UNSIGNED, 1, U32MaxPat});
      directed.push_back('{64'hFFEF_FFFF_FFFF_FFFF, MODE_SIGNED,   1, S32MinPat});
      directed.push_back('{64'h400C_0000_0000_0000, MODE_SIGNED,   1, 32'h3});
      directed.push_back('{64'hC00C_0000_0000_0000, MODE_SIGNED,   0, 32'h0});

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i]) begin
         if (directed[i].has_known &&
             truncate_to_int(directed[i].bits, directed[i].mode) !== directed[i].known) begin
            $error("int_result: expected %h, actual %h (predictor, row %0d)",
                   directed[i].known,
                   truncate_to_int(directed[i].bits, directed[i].mode), i);
            error_count++;
         end
         send_beat(directed[i].bits, directed[i].mode, 1'b1);
      end

      // Hold off until every result so far has come back.
      start <= 1'b0;
      while (pending_ints.size() != 0) @(posedge clock);

      // Random beats; a long stretch in the middle runs back to back.
      for (int n = 0; n < RandomBeats; n++) begin
         rbits = ($urandom_range(0, 19) == 0) ? {$urandom, $urandom} : random_double();
         rmode = 1'($urandom);
         send_beat(rbits, rmode, !(n >= 300 && n < 450));
      end
      start <= 1'b0;

      waited = 0;
      while (pending_ints.size() != 0 && waited < 1000) begin
         @(posedge clock);
         waited++;
      end
      repeat (LatencyCycles + 4) @(posedge clock);
      if (error_count == 0 && pending_ints.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // Overall limit, far beyond the slowest correct run.
   initial begin
      #2ms;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule
